// ----- src/dqs_pkg.sv -----
// shared types for the deque with search unit
// request codes and the command and status bundles between controller and datapath
// no dependencies
package dqs_pkg;

   // request codes carried on req_type
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_DROP_FRONT = 3'd2,
      OP_DROP_BACK  = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   // width of the result count field
   localparam int unsigned RSP_COUNT_W = 5;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec_op;
      logic srch_start;
      logic srch_step;
      logic rsp_load_srch;
   } dqs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_search;
      logic srch_done;
   } dqs_stat_type;

endpackage

// ----- src/deque_with_search_unit.sv -----
// Bounded deque of signed 32-bit values with a membership scan.
// Push and drop requests: the request is captured, then its result is loaded when the result
// register is free; only then is the next request taken. Search: result and next request wait
// for a scan of the occupied slots, one slot memory read a cycle, paced by the single-port slot memory.
// Synchronous active-high reset empties the queue (head 0, count 0); slot contents are kept.
// Depends on dqs_pkg, dqs_ctrl and dqs_dp.
module deque_with_search_unit #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic signed [31:0]             req_item_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic                           rsp_full_reject,
   output logic [dqs_pkg::RSP_COUNT_W-1:0] rsp_element_count,
   output logic                           rsp_is_empty
);
   import dqs_pkg::*;

   dqs_cmd_type  cmd;
   dqs_stat_type stat;

   // sequencing
   dqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage and compute
   dqs_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .rsp_ok            (rsp_ok),
      .rsp_full_reject   (rsp_full_reject),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

// ----- src/dqs_ctrl.sv -----
// controller state machine for the deque with search unit
// sequences request capture, execution, the slot scan and the result register
// depends on dqs_pkg
module dqs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dqs_pkg::dqs_cmd_type  cmd,
   input  dqs_pkg::dqs_stat_type stat
);
   import dqs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SRCH,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // result register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands decoded from state
   always_comb begin
      cmd               = '0;
      cmd.load_req      = (state_ff == ST_IDLE) && req_valid;
      cmd.srch_start    = (state_ff == ST_EXEC) && stat.is_search;
      cmd.exec_op       = (state_ff == ST_EXEC) && !stat.is_search && out_free;
      cmd.srch_step     = (state_ff == ST_SRCH);
      cmd.rsp_load_srch = (state_ff == ST_RESP) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (stat.is_search) state_in = ST_SRCH;
            else if (out_free)  state_in = ST_IDLE;
         end
         ST_SRCH: begin
            if (stat.srch_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec_op || cmd.rsp_load_srch) rsp_valid_in = 1'b1;
      else if (!rsp_stall)                  rsp_valid_in = 1'b0;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // accepted request always moves to execution
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execution");

   // an executed push or drop shows a result next cycle
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      cmd.exec_op |=> rsp_valid)
      else $error("executed request gave no result");

   // finished scan goes to the result state
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH && stat.srch_done) |=> (state_ff == ST_RESP))
      else $error("finished scan did not move to result");

endmodule

// ----- src/dqs_dp.sv -----
// datapath for the deque with search unit
// circular slot memory, head and count registers, scan logic and result registers
// depends on dqs_pkg
module dqs_dp #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dqs_pkg::dqs_cmd_type           cmd,
   output dqs_pkg::dqs_stat_type          stat,
   input  logic [2:0]                     req_type,
   input  logic signed [31:0]             req_item_value,
   output logic                           rsp_ok,
   output logic                           rsp_full_reject,
   output logic [dqs_pkg::RSP_COUNT_W-1:0] rsp_element_count,
   output logic                           rsp_is_empty
);
   import dqs_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned SW = CW + 1;

   // slot memory, single port with registered read
   logic [31:0]        mem [CAPACITY];
   logic [31:0]        rd_data_ff;

   op_type             op_ff;
   logic signed [31:0] value_ff;
   logic [AW-1:0]      head_ff;
   logic [AW-1:0]      head_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      idx_in;
   logic               pend_ff;
   logic               pend_in;
   logic               found_ff;
   logic               found_in;

   logic               rsp_ok_ff;
   logic               rsp_reject_ff;
   logic [CW-1:0]      rsp_count_ff;

   logic               full;
   logic               empty;
   logic               issue;
   logic [CW-1:0]      offset;
   logic [SW-1:0]      sum;
   logic [AW-1:0]      wrap_addr;
   logic [AW-1:0]      head_dec;
   logic [AW-1:0]      head_inc;
   logic [AW-1:0]      mem_addr;
   logic               mem_we;
   logic               mem_re;
   logic               ex_ok;
   logic               ex_reject;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);
   assign issue = cmd.srch_step && (idx_ff < count_ff);

   // head plus offset, wrapped into the ring
   assign offset = cmd.srch_step ? idx_ff : count_ff;
   always_comb begin
      sum = SW'(head_ff) + SW'(offset);
      if (sum >= SW'(CAPACITY)) sum = sum - SW'(CAPACITY);
      wrap_addr = sum[AW-1:0];
   end

   assign head_dec = (head_ff == '0) ? AW'(CAPACITY - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(CAPACITY - 1)) ? '0 : head_ff + AW'(1);

   // push, drop and no-op execution
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      ex_ok     = 1'b0;
      ex_reject = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = wrap_addr;
      case (op_ff)
         OP_PUSH_FRONT: begin
            mem_addr = head_dec;
            if (full) begin
               ex_reject = 1'b1;
            end else begin
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
               mem_we   = 1'b1;
               ex_ok    = 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               ex_reject = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
               mem_we   = 1'b1;
               ex_ok    = 1'b1;
            end
         end
         OP_DROP_FRONT: begin
            if (!empty) begin
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
               ex_ok    = 1'b1;
            end
         end
         OP_DROP_BACK: begin
            if (!empty) begin
               count_in = count_ff - CW'(1);
               ex_ok    = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!cmd.exec_op) begin
         head_in  = head_ff;
         count_in = count_ff;
         mem_we   = 1'b0;
      end
   end

   assign mem_re = issue;

   // slot memory access
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= value_ff;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   // scan: issue one read a cycle, compare the previous read
   always_comb begin
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      if (cmd.srch_start) begin
         idx_in   = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end else if (cmd.srch_step) begin
         if (issue) idx_in = idx_ff + CW'(1);
         pend_in = issue;
         if (pend_ff && (rd_data_ff == value_ff)) found_in = 1'b1;
      end
   end

   assign stat.is_search = (op_ff == OP_SEARCH);
   assign stat.srch_done = !issue && !pend_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // request capture, scan index and match flag
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_type);
         value_ff <= req_item_value;
      end
      idx_ff   <= idx_in;
      found_ff <= found_in;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.exec_op) begin
         rsp_ok_ff     <= ex_ok;
         rsp_reject_ff <= ex_reject;
         rsp_count_ff  <= count_in;
      end else if (cmd.rsp_load_srch) begin
         rsp_ok_ff     <= found_ff;
         rsp_reject_ff <= 1'b0;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_full_reject   = rsp_reject_ff;
   assign rsp_element_count = RSP_COUNT_W'(rsp_count_ff);
   assign rsp_is_empty      = (rsp_count_ff == '0);

   // count never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   // head stays inside the ring
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      SW'(head_ff) < SW'(CAPACITY))
      else $error("head index outside ring");

   // scan starts clean
   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_start |=> (!found_ff && !pend_ff && idx_ff == '0))
      else $error("scan did not start clean");

endmodule

// ----- bench/deque_with_search_checker.sv -----
// result checker for the deque with search unit
// watches both channels, keeps its own copy of the deque and compares every result transfer
// depends on dqs_pkg
module deque_with_search_checker #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [2:0]                      req_type,
   input  logic signed [31:0]              req_item_value,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_ok,
   input  logic                            rsp_full_reject,
   input  logic [dqs_pkg::RSP_COUNT_W-1:0] rsp_element_count,
   input  logic                            rsp_is_empty,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                            ok;
      logic                            full_reject;
      logic [dqs_pkg::RSP_COUNT_W-1:0] count;
      logic                            is_empty;
   } deque_status_type;

   // shadow deque contents and the statuses still owed by the block
   logic [31:0]      shadow_slots [CAPACITY];
   int unsigned      shadow_front;
   int unsigned      shadow_fill;
   deque_status_type owed_status_q[$];
   deque_status_type oldest_status;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic int unsigned ring_slot(int unsigned base, int unsigned offset);
      return (base + offset) % CAPACITY;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // apply one request to the shadow deque and queue the status it must produce
   task automatic apply_deque_request(logic [2:0] op, logic [31:0] value);
      deque_status_type status;
      status = '0;
      case (op)
         dqs_pkg::OP_PUSH_FRONT: begin
            if (shadow_fill >= CAPACITY) begin
               status.full_reject = 1'b1;
            end else begin
               shadow_front = ring_slot(shadow_front, CAPACITY - 1);
               shadow_slots[shadow_front] = value;
               shadow_fill++;
               status.ok = 1'b1;
            end
         end
         dqs_pkg::OP_PUSH_BACK: begin
            if (shadow_fill >= CAPACITY) begin
               status.full_reject = 1'b1;
            end else begin
               shadow_slots[ring_slot(shadow_front, shadow_fill)] = value;
               shadow_fill++;
               status.ok = 1'b1;
            end
         end
         dqs_pkg::OP_DROP_FRONT: begin
            if (shadow_fill != 0) begin
               shadow_front = ring_slot(shadow_front, 1);
               shadow_fill--;
               status.ok = 1'b1;
            end
         end
         dqs_pkg::OP_DROP_BACK: begin
            if (shadow_fill != 0) begin
               shadow_fill--;
               status.ok = 1'b1;
            end
         end
         dqs_pkg::OP_SEARCH: begin
            // only occupied slots are looked at
            for (int unsigned i = 0; i < shadow_fill; i++) begin
               if (shadow_slots[ring_slot(shadow_front, i)] == value) status.ok = 1'b1;
            end
         end
         default: ;
      endcase
      status.count    = shadow_fill[dqs_pkg::RSP_COUNT_W-1:0];
      status.is_empty = (shadow_fill == 0);
      owed_status_q.push_back(status);
   endtask

   // compare result transfers first, then predict from the request transfer of the same edge
   always @(posedge clock) begin
      if (reset) begin
         shadow_front = 0;
         shadow_fill  = 0;
         owed_status_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (owed_status_q.size() == 0) begin
               report_mismatch("result with nothing pending", 1, 0);
            end else begin
               oldest_status = owed_status_q.pop_front();
               if (rsp_ok !== oldest_status.ok)
                  report_mismatch("ok", int'(rsp_ok), int'(oldest_status.ok));
               if (rsp_full_reject !== oldest_status.full_reject)
                  report_mismatch("full_reject", int'(rsp_full_reject),
                                  int'(oldest_status.full_reject));
               if (rsp_element_count !== oldest_status.count)
                  report_mismatch("element_count", int'(rsp_element_count),
                                  int'(oldest_status.count));
               if (rsp_is_empty !== oldest_status.is_empty)
                  report_mismatch("is_empty", int'(rsp_is_empty), int'(oldest_status.is_empty));
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            apply_deque_request(req_type, req_item_value);
      end
      pending_count <= owed_status_q.size();
   end

endmodule

// ----- bench/deque_with_search_unit_tb.sv -----
// top of the deque with search unit testbench: clock, reset, stimulus and verdict
// runs directed corner requests, then random fill, drain and mixed phases with random idling
// depends on dqs_pkg, deque_with_search_unit and deque_with_search_checker
module deque_with_search_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CAPACITY       = 16;
   localparam int          RANDOM_ITEMS   = 800;
   localparam int          IDLE_PERCENT   = 26;
   localparam int          QUIET_LIMIT    = 5000;
   localparam int          DRAIN_CYCLES   = CAPACITY + 12;
   localparam logic [2:0]  SPARE_CODE_LO  = 3'd5;
   localparam logic [2:0]  SPARE_CODE_MID = 3'd6;
   localparam logic [2:0]  SPARE_CODE_HI  = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_kind_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [2:0]                      req_type = '0;
   logic signed [31:0]              req_item_value = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_ok;
   logic                            rsp_full_reject;
   logic [dqs_pkg::RSP_COUNT_W-1:0] rsp_element_count;
   logic                            rsp_is_empty;
   logic                            steady_flow = 1'b0;
   int                              fail_count;
   int                              pending_count;
   int                              quiet_cycles = 0;
   logic [31:0]                     recent_values[$];

   always #5 clock = ~clock;

   deque_with_search_unit #(.CAPACITY(CAPACITY)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_full_reject   (rsp_full_reject),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   deque_with_search_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp_ok),
      .rsp_full_reject   (rsp_full_reject),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   // random backpressure on the result side
   always @(posedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_request(logic [2:0] op, logic [31:0] value);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_item_value <= value;
      if (op == dqs_pkg::OP_PUSH_FRONT || op == dqs_pkg::OP_PUSH_BACK) begin
         recent_values.push_back(value);
         if (recent_values.size() > 24) void'(recent_values.pop_front());
      end
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // corners, fresh random words, or values pushed lately so searches hit
   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(4))
               0:       return 32'h0000_0000;
               1:       return 32'hFFFF_FFFF;
               2:       return 32'h7FFF_FFFF;
               3:       return 32'h8000_0000;
               default: return 32'($urandom_range(3));
            endcase
         end
         1: return $urandom;
         default: begin
            if (recent_values.size() == 0) return $urandom;
            return recent_values[$urandom_range(recent_values.size() - 1)];
         end
      endcase
   endfunction

   function automatic logic [2:0] pick_op(mix_kind_type mix);
      int         roll;
      int         push_pct;
      int         drop_pct;
      logic [2:0] push_op;
      logic [2:0] drop_op;
      roll     = $urandom_range(99);
      push_op  = $urandom_range(1) ? dqs_pkg::OP_PUSH_BACK : dqs_pkg::OP_PUSH_FRONT;
      drop_op  = $urandom_range(1) ? dqs_pkg::OP_DROP_BACK : dqs_pkg::OP_DROP_FRONT;
      push_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 15 : 35;
      drop_pct = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 60 : 35;
      if (roll < 5) return 3'($urandom_range(SPARE_CODE_HI, SPARE_CODE_LO));
      if (roll < 5 + push_pct) return push_op;
      if (roll < 5 + push_pct + drop_pct) return drop_op;
      return dqs_pkg::OP_SEARCH;
   endfunction

   initial begin
      int           segment_left;
      mix_kind_type mix;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: drops fail, search misses, spare codes do nothing
      send_request(dqs_pkg::OP_SEARCH, 32'h0000_0000);
      send_request(dqs_pkg::OP_DROP_FRONT, 32'hFFFF_FFFF);
      send_request(dqs_pkg::OP_DROP_BACK, 32'h0000_0000);
      send_request(SPARE_CODE_LO, 32'h7FFF_FFFF);
      send_request(SPARE_CODE_MID, 32'h8000_0000);
      send_request(SPARE_CODE_HI, 32'hFFFF_FFFF);
      // extreme values at both ends, front push wraps the head
      send_request(dqs_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(dqs_pkg::OP_PUSH_BACK, 32'h8000_0000);
      send_request(dqs_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_request(dqs_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_request(SPARE_CODE_HI, 32'h0000_0000);
      send_request(dqs_pkg::OP_SEARCH, 32'h8000_0000);
      send_request(dqs_pkg::OP_SEARCH, 32'h7FFF_FFFE);
      send_request(dqs_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      // drops at both ends, then searches for a gone and a kept value
      send_request(dqs_pkg::OP_DROP_BACK, 32'h1234_5678);
      send_request(dqs_pkg::OP_DROP_FRONT, 32'h0000_0000);
      send_request(dqs_pkg::OP_SEARCH, 32'hFFFF_FFFF);
      send_request(dqs_pkg::OP_SEARCH, 32'h7FFF_FFFF);
      send_request(dqs_pkg::OP_DROP_FRONT, 32'h0000_0000);
      send_request(dqs_pkg::OP_DROP_BACK, 32'h0000_0000);
      send_request(dqs_pkg::OP_SEARCH, 32'h8000_0000);
      wait_for_results();

      // random phases that fill to full, drain to empty or mix
      segment_left = 0;
      mix          = MIX_EVEN;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (segment_left == 0) begin
            mix          = mix_kind_type'($urandom_range(2));
            segment_left = $urandom_range(60, 20);
         end
         segment_left--;
         if (n == 300) steady_flow <= 1'b1;
         if (n == 420) steady_flow <= 1'b0;
         if (n == 500) wait_for_results();
         send_request(pick_op(mix), pick_value());
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
